FILE: rtl/core/slist_pkg.sv
// ----------------------------------------------------------------------------
// slist_pkg
// Shared types and codes for the sorted list engine: field widths, opcodes,
// status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package slist_pkg;

   // Field widths
   localparam int DATA_W = 32;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_DUMP   = 2'd3;

   // Response status codes
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_INS     = 5'b00010,
      S_INS_LOW = 5'b00100,
      S_DEL     = 5'b01000,
      S_DUMP    = 5'b10000
   } state_type;

endpackage

FILE: rtl/core/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// Ascending list of up to CAPACITY signed 32-bit values held in a memory with
// one write and one read port, with insert, delete-first-equal, clear and in-order dump.
//
// A transaction is taken when start is high and busy is low. Clear, insert
// into a full or empty list, and delete or dump on an empty list answer
// from idle: busy stays low and the one result appears on the next cycle.
// Otherwise busy is held while insert walks down from the top, shifting
// entries not below the value up one place, delete walks up and closes the
// gap, and dump walks up with one result per entry on consecutive cycles.
// The walks are set by the memory: one read and one write per cycle, with a
// registered read. Every result shows for one cycle on rsp_valid and must be
// taken then; rsp_last marks the final result of each transaction.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
   parameter int CAPACITY = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [slist_pkg::OP_W-1:0]          req_opcode,
   input  logic signed [slist_pkg::DATA_W-1:0] req_value,
   output logic                                busy,
   output logic                                rsp_valid,
   output logic [slist_pkg::ST_W-1:0]          rsp_status,
   output logic signed [slist_pkg::DATA_W-1:0] rsp_entry,
   output logic                                rsp_last
);
   import slist_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Sequencer and control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   iss_idx_ff, iss_idx_in;   // address being read
   logic               iss_act_ff, iss_act_in;
   logic [IDX_W-1:0]   proc_idx_ff, proc_idx_in; // address of rd_data_ff
   logic               proc_vld_ff, proc_vld_in;
   logic               found_ff, found_in;
   logic [DATA_W-1:0]  val_ff, val_in;

   // Result registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_entry_ff, rsp_entry_in;
   logic               rsp_last_ff, rsp_last_in;

   // Memory port
   logic [DATA_W-1:0]  mem [CAPACITY];
   logic [DATA_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic [DATA_W-1:0]  mem_wd;

   // Shared compare unit
   logic               is_less;
   logic               is_equal;
   logic [IDX_W-1:0]   last_idx;

   assign is_less  = $signed(rd_data_ff) < $signed(val_ff);
   assign is_equal = rd_data_ff == val_ff;
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   // Storage: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[iss_idx_ff];
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      iss_idx_in    = iss_idx_ff;
      iss_act_in    = iss_act_ff;
      proc_idx_in   = iss_idx_ff;
      proc_vld_in   = iss_act_ff;
      found_in      = found_ff;
      val_in        = val_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = val_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_entry_in  = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               val_in   = req_value;
               found_in = 1'b0;
               unique case (req_opcode)
                  OP_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else if (count_ff == '0) begin
                        mem_we       = 1'b1;
                        mem_wa       = '0;
                        mem_wd       = req_value;
                        count_in     = CNT_W'(1);
                        rsp_valid_in = 1'b1;
                     end else begin
                        iss_idx_in = last_idx;
                        iss_act_in = 1'b1;
                        state_in   = S_INS;
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        iss_idx_in = '0;
                        iss_act_in = 1'b1;
                        state_in   = S_DEL;
                     end
                  end
                  OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        iss_idx_in = '0;
                        iss_act_in = 1'b1;
                        state_in   = S_DUMP;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Walk down from the top, moving entries not below the value up one
         S_INS: begin
            if (iss_act_ff) begin
               iss_idx_in = iss_idx_ff - IDX_W'(1);
               iss_act_in = iss_idx_ff != '0;
            end
            if (proc_vld_ff) begin
               mem_we = 1'b1;
               mem_wa = proc_idx_ff + IDX_W'(1);
               if (is_less) begin
                  mem_wd       = val_ff;
                  count_in     = count_ff + CNT_W'(1);
                  rsp_valid_in = 1'b1;
                  iss_act_in   = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  mem_wd = rd_data_ff;
                  if (proc_idx_ff == '0) begin
                     iss_act_in = 1'b0;
                     state_in   = S_INS_LOW;
                  end
               end
            end
         end

         // Every entry was shifted: the value goes to the bottom
         S_INS_LOW: begin
            mem_we       = 1'b1;
            mem_wa       = '0;
            mem_wd       = val_ff;
            count_in     = count_ff + CNT_W'(1);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         // Walk up, find the first match, then move later entries down one
         S_DEL: begin
            if (iss_act_ff) begin
               iss_idx_in = iss_idx_ff + IDX_W'(1);
               iss_act_in = iss_idx_ff != last_idx;
            end
            if (proc_vld_ff) begin
               if (found_ff) begin
                  mem_we = 1'b1;
                  mem_wa = proc_idx_ff - IDX_W'(1);
                  mem_wd = rd_data_ff;
               end
               found_in = found_ff | is_equal;
               if (proc_idx_ff == last_idx) begin
                  rsp_valid_in = 1'b1;
                  iss_act_in   = 1'b0;
                  state_in     = S_IDLE;
                  if (found_ff | is_equal) begin
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               end
            end
         end

         // Stream entries out in order
         S_DUMP: begin
            if (iss_act_ff) begin
               iss_idx_in = iss_idx_ff + IDX_W'(1);
               iss_act_in = iss_idx_ff != last_idx;
            end
            if (proc_vld_ff) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = rd_data_ff;
               rsp_last_in  = proc_idx_ff == last_idx;
               if (proc_idx_ff == last_idx) begin
                  iss_act_in = 1'b0;
                  state_in   = S_IDLE;
               end
            end
         end

         default: begin
            state_in   = S_IDLE;
            iss_act_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         iss_act_ff   <= 1'b0;
         proc_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_act_ff   <= iss_act_in;
         proc_vld_ff  <= proc_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      iss_idx_ff    <= iss_idx_in;
      proc_idx_ff   <= proc_idx_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry  = rsp_entry_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: rtl/core/slist_checker.sv
// ----------------------------------------------------------------------------
// slist_checker
// Port-level checks for the sorted list engine, bound to the engine module.
// ----------------------------------------------------------------------------
module slist_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic [slist_pkg::OP_W-1:0]          req_opcode,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic [slist_pkg::ST_W-1:0]          rsp_status,
   input logic signed [slist_pkg::DATA_W-1:0] rsp_entry,
   input logic                                rsp_last
);
   import slist_pkg::*;

   // A result only follows an accepted transaction still in progress
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start && !busy))
      else $error("result without a transaction");

   // More dump results follow a non-final one, so the engine stays busy
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result while idle");

   // Error statuses are single, final and carry no entry
   a_err_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_entry == '0)
      else $error("error result not final or has entry");

   // Clear answers ok in the next cycle
   a_clear_resp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == OP_CLEAR |=>
         rsp_valid && rsp_status == ST_OK && rsp_last && !busy)
      else $error("clear response missing");

endmodule

bind sorted_list_engine slist_checker u_slist_checker (.*);
